// ----- hw/rtl/rap_pkg.sv -----
// ----------------------------------------------------------------------------
// rap_pkg: shared definitions of the ramped attitude PID
// Formats, gains, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rap_pkg;

   localparam int ANGLE_WIDTH_DEF = 32;
   localparam int TIME_WIDTH_DEF  = 32;
   localparam int AXES            = 3;
   localparam int QW              = 48;   // Q8.40 internal word
   localparam int GAIN_W          = 34;
   localparam int GAIN_SHIFT      = 40;
   localparam int MAG_W           = 50;   // multiplicand magnitude
   localparam int DIVQ_W          = 49;   // dividend / quotient width
   localparam int FRAC_BITS       = 32;
   localparam int STEP_W          = 6;

   localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd32;
   localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd49;

   localparam logic [1:0] REG_TARGET_X  = 2'd0;
   localparam logic [1:0] REG_TARGET_Y  = 2'd1;
   localparam logic [1:0] REG_TARGET_Z  = 2'd2;
   localparam logic [1:0] REG_RAMP_TIME = 2'd3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_P [AXES] = '{34'd219902326, 34'd219902326,
                                                   34'd219902326};
   localparam logic [GAIN_W-1:0] GAIN_D [AXES] = '{34'd6095692464, 34'd6349679650,
                                                   34'd5769357413};
   localparam logic [GAIN_W-1:0] GAIN_I [AXES] = '{34'd10995116, 34'd10555312,
                                                   34'd11621838};

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_FRAC_GO,
      ST_FRAC_WAIT,
      ST_SCALE_GO,
      ST_SCALE_WAIT,
      ST_ERR,
      ST_KD_GO,
      ST_KD_WAIT,
      ST_NUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EDT_GO,
      ST_EDT_WAIT,
      ST_INT,
      ST_KP_GO,
      ST_KP_WAIT,
      ST_KI_GO,
      ST_KI_WAIT,
      ST_SUM,
      ST_SAT,
      ST_DONE
   } rap_state_type;

   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse, result valid
   } rap_unit_stat_type;

   // saturate a 50-bit signed value to the 48-bit word
   function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+1:0] x);
      logic fits;
      fits = (&x[QW+1:QW-1]) | ~(|x[QW+1:QW-1]);
      if (fits)
         return x[QW-1:0];
      else if (x[QW+1])
         return {1'b1, {(QW-1){1'b0}}};
      else
         return {1'b0, {(QW-1){1'b1}}};
   endfunction

   function automatic logic signed [QW+1:0] apply_sign(input logic [QW:0] m,
                                                        input logic neg);
      logic signed [QW+1:0] z;
      z = $signed({1'b0, m});
      return neg ? -z : z;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rap_mul.sv -----
// ----------------------------------------------------------------------------
// rap_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle; done pulses after BW steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_mul #(
   parameter int BW = 34
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [rap_pkg::MAG_W-1:0]       a,
   input  wire logic [BW-1:0]                   b,
   output logic [rap_pkg::MAG_W+BW-1:0]         prod,
   output rap_pkg::rap_unit_stat_type           stat
);

   localparam int PW    = rap_pkg::MAG_W + BW;
   localparam int CNT_W = $clog2(BW);

   logic [PW-1:0]             acc_ff, acc_in;
   logic [rap_pkg::MAG_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [rap_pkg::MAG_W:0]   sum;

   always_comb begin
      sum     = {1'b0, acc_ff[PW-1:BW]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{rap_pkg::MAG_W{1'b0}}, b};
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign prod      = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rap_div.sv -----
// ----------------------------------------------------------------------------
// rap_div: bit-serial restoring divider
// One quotient bit per cycle for a given number of steps, from a preset
// partial remainder; serves both the ramp fraction and the derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module rap_div #(
   parameter int TW = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rap_pkg::STEP_W-1:0]    steps,
   input  wire logic [TW:0]                   r0,
   input  wire logic [rap_pkg::DIVQ_W-1:0]    q0,
   input  wire logic [TW:0]                   d,
   output logic [rap_pkg::DIVQ_W-1:0]         quot,
   output rap_pkg::rap_unit_stat_type         stat
);

   logic [TW:0]                   r_ff, r_in;
   logic [rap_pkg::DIVQ_W-1:0]    q_ff, q_in;
   logic [TW:0]                   d_ff, d_in;
   logic [rap_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [TW+1:0]                 t, t_sub;
   logic                          ge;

   always_comb begin
      t       = {r_ff, q_ff[rap_pkg::DIVQ_W-1]};
      t_sub   = t - {1'b0, d_ff};
      ge      = t >= {1'b0, d_ff};
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = r0;
         q_in    = q0;
         d_in    = d;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = ge ? t_sub[TW:0] : t[TW:0];
         q_in   = {q_ff[rap_pkg::DIVQ_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rap_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ramped_attitude_pid.sv -----
// ----------------------------------------------------------------------------
// ramped_attitude_pid: three-axis attitude PID with ramped setpoint
// Filtered derivative, saturating integral, negated torque output.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per sample. req_tuser = 0 is a start beat: it
//   captures the attitude and time as the ramp origin, clears error,
//   derivative and integral, and produces no result. req_tuser = 1 is a
//   control step and produces one rsp beat with three Q8.40 torques and
//   the ramp_done flag in rsp_tuser.
//   csr_* writes targets and ramp time; write only while the block is idle.
//   Every product runs through one shared shift-add multiplier of BW bits,
//   BW being the larger of TIME_WIDTH and 34, at one bit per cycle; the
//   ramp fraction and the derivative run through one restoring divider at
//   one bit per cycle. A start beat leaves the sequencer idle.
//   req_tready is high while the sequencer is idle, also while a result
//   waits on rsp. If rsp is stalled when the next step finishes, the block
//   holds that result until the output frees up.
//   Reset (synchronous) clears targets, ramp time, ramp origin, stored error,
//   derivative and integral, the sequencer state and rsp_tvalid.
`default_nettype none

module ramped_attitude_pid #(
   parameter int ANGLE_WIDTH = rap_pkg::ANGLE_WIDTH_DEF,
   parameter int TIME_WIDTH  = rap_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // attitude_x, attitude_y, attitude_z, sample_time (low to high)
   input  wire logic [((3*ANGLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // op
   input  wire logic                          req_tuser,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // torque_x, torque_y, torque_z (low to high)
   output logic [((3*rap_pkg::QW+7)/8)*8-1:0] rsp_tdata,
   // ramp_done
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_addr,
   input  wire logic [((ANGLE_WIDTH > 32) ? ANGLE_WIDTH : 32)-1:0] csr_wdata
);

   localparam int AW     = ANGLE_WIDTH;
   localparam int TW     = TIME_WIDTH;
   localparam int QW     = rap_pkg::QW;
   localparam int FS     = QW - AW;
   localparam int BW     = (TW > rap_pkg::GAIN_W) ? TW : rap_pkg::GAIN_W;
   localparam int PW     = rap_pkg::MAG_W + BW;
   localparam int RSP_W  = ((3*QW+7)/8)*8;
   localparam logic [PW-1:0] CLAMP = PW'(1) << QW;

   rap_pkg::rap_state_type state_ff, state_in;

   logic signed [AW-1:0]   target_ff [rap_pkg::AXES];
   logic signed [AW-1:0]   init_ff   [rap_pkg::AXES];
   logic signed [AW-1:0]   lerr_ff   [rap_pkg::AXES];
   logic signed [AW-1:0]   meas_ff   [rap_pkg::AXES];
   logic signed [QW-1:0]   fd_ff     [rap_pkg::AXES];
   logic signed [QW-1:0]   int_ff    [rap_pkg::AXES];
   logic signed [QW-1:0]   tq_ff     [rap_pkg::AXES];
   logic [31:0]            ramp_ff;
   logic [TW-1:0]          start_ff, last_ff, now_ff, dt_ff, since_ff;
   logic                   ramp_done_ff;
   logic [rap_pkg::FRAC_BITS-1:0] frac_ff;
   logic [1:0]             axis_ff;
   logic                   sgn_ff;
   logic signed [AW-1:0]   e_ff;
   logic signed [AW+1:0]   sp_ff;
   logic signed [QW-1:0]   eq_ff, d_ff;
   logic signed [QW+1:0]   mgd_ff, num_ff, p_ff, tp_ff, ti_ff, sum_ff;
   logic [RSP_W-1:0]       rsp_data_ff;
   logic                   rsp_user_ff, rsp_valid_ff;

   // unit hookup
   logic                          mul_start, div_start;
   logic [rap_pkg::MAG_W-1:0]     mul_a;
   logic [BW-1:0]                 mul_b;
   logic [PW-1:0]                 mul_prod;
   logic [QW:0]                   gain_prod;
   logic [rap_pkg::STEP_W-1:0]    div_steps;
   logic [TW:0]                   div_r0, div_d;
   logic [rap_pkg::DIVQ_W-1:0]    div_q0, div_quot;
   rap_pkg::rap_unit_stat_type    mul_stat, div_stat;

   // datapath helpers
   logic [TW-1:0]          rt, now_in;
   logic                   req_acc, out_free, last_axis;
   logic signed [AW-1:0]   att_in [rap_pkg::AXES];
   logic signed [AW:0]     diff_s;
   logic [AW:0]            diff_mag;
   logic signed [AW+1:0]   q_s, sp_calc;
   logic signed [AW+2:0]   e_raw;
   logic signed [AW-1:0]   e_sat;
   logic signed [QW-1:0]   eq_cur, epq;
   logic signed [QW:0]     diffq;
   logic [QW:0]            diffq_mag;
   logic [QW-1:0]          eq_mag, int_mag;
   logic [QW+1:0]          num_mag;
   logic [QW:0]            pm, qv;

   assign rt        = TW'(ramp_ff);
   assign req_acc   = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_axis = axis_ff == 2'd2;
   assign now_in    = req_tdata[3*AW +: TW];

   always_comb begin
      for (int i = 0; i < rap_pkg::AXES; i++) begin
         att_in[i] = req_tdata[i*AW +: AW];
      end
   end

   assign diff_s    = (AW+1)'(target_ff[axis_ff]) - (AW+1)'(init_ff[axis_ff]);
   assign diff_mag  = diff_s[AW] ? (AW+1)'(-diff_s) : (AW+1)'(diff_s);
   assign q_s       = $signed({1'b0, mul_prod[rap_pkg::FRAC_BITS +: AW+1]});
   assign sp_calc   = (AW+2)'(init_ff[axis_ff]) + (sgn_ff ? -q_s : q_s);
   assign e_raw     = (AW+3)'(sp_ff) - (AW+3)'(meas_ff[axis_ff]);

   always_comb begin
      if ((&e_raw[AW+2:AW-1]) | ~(|e_raw[AW+2:AW-1]))
         e_sat = e_raw[AW-1:0];
      else if (e_raw[AW+2])
         e_sat = {1'b1, {(AW-1){1'b0}}};
      else
         e_sat = {1'b0, {(AW-1){1'b1}}};
   end

   assign eq_cur    = QW'(e_ff) <<< FS;
   assign epq       = QW'(lerr_ff[axis_ff]) <<< FS;
   assign diffq     = (QW+1)'(eq_cur) - (QW+1)'(epq);
   assign diffq_mag = diffq[QW] ? (QW+1)'(-diffq) : (QW+1)'(diffq);
   assign eq_mag    = eq_ff[QW-1] ? QW'(-eq_ff) : QW'(eq_ff);
   assign int_mag   = int_ff[axis_ff][QW-1] ? QW'(-int_ff[axis_ff]) : QW'(int_ff[axis_ff]);
   assign num_mag   = num_ff[QW+1] ? (QW+2)'(-num_ff) : (QW+2)'(num_ff);
   // gain products scaled down by 2^40
   assign gain_prod = (QW+1)'(mul_prod[PW-1:rap_pkg::GAIN_SHIFT]);
   // e*dt magnitude is clamped to 2^48
   assign pm        = (mul_prod > CLAMP) ? CLAMP[QW:0] : mul_prod[QW:0];
   // at a time width of 64 bits or more, an all-ones dt forces the quotient to zero
   assign qv        = ((TW >= 64) && (&dt_ff)) ? '0 : div_quot;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rap_pkg::ST_IDLE:
            if (req_acc && req_tuser == rap_pkg::OP_STEP) state_in = rap_pkg::ST_PREP;
         rap_pkg::ST_PREP:       state_in = rap_pkg::ST_FRAC_GO;
         rap_pkg::ST_FRAC_GO:    state_in = rap_pkg::ST_FRAC_WAIT;
         rap_pkg::ST_FRAC_WAIT:
            if (div_stat.done) state_in = rap_pkg::ST_SCALE_GO;
         rap_pkg::ST_SCALE_GO:   state_in = rap_pkg::ST_SCALE_WAIT;
         rap_pkg::ST_SCALE_WAIT:
            if (mul_stat.done) state_in = rap_pkg::ST_ERR;
         rap_pkg::ST_ERR:        state_in = rap_pkg::ST_KD_GO;
         rap_pkg::ST_KD_GO:      state_in = rap_pkg::ST_KD_WAIT;
         rap_pkg::ST_KD_WAIT:
            if (mul_stat.done) state_in = rap_pkg::ST_NUM;
         rap_pkg::ST_NUM:        state_in = rap_pkg::ST_DIV_GO;
         rap_pkg::ST_DIV_GO:     state_in = rap_pkg::ST_DIV_WAIT;
         rap_pkg::ST_DIV_WAIT:
            if (div_stat.done) state_in = rap_pkg::ST_EDT_GO;
         rap_pkg::ST_EDT_GO:     state_in = rap_pkg::ST_EDT_WAIT;
         rap_pkg::ST_EDT_WAIT:
            if (mul_stat.done) state_in = rap_pkg::ST_INT;
         rap_pkg::ST_INT:        state_in = rap_pkg::ST_KP_GO;
         rap_pkg::ST_KP_GO:      state_in = rap_pkg::ST_KP_WAIT;
         rap_pkg::ST_KP_WAIT:
            if (mul_stat.done) state_in = rap_pkg::ST_KI_GO;
         rap_pkg::ST_KI_GO:      state_in = rap_pkg::ST_KI_WAIT;
         rap_pkg::ST_KI_WAIT:
            if (mul_stat.done) state_in = rap_pkg::ST_SUM;
         rap_pkg::ST_SUM:        state_in = rap_pkg::ST_SAT;
         rap_pkg::ST_SAT:
            state_in = last_axis ? rap_pkg::ST_DONE : rap_pkg::ST_SCALE_GO;
         rap_pkg::ST_DONE:
            if (out_free) state_in = rap_pkg::ST_IDLE;
         default:                state_in = rap_pkg::ST_IDLE;
      endcase
   end

   // unit launches and operands
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_steps = '0;
      div_r0    = '0;
      div_q0    = '0;
      div_d     = '0;
      unique case (state_ff)
         rap_pkg::ST_FRAC_GO: begin
            div_start = 1'b1;
            div_steps = rap_pkg::FRAC_STEPS;
            div_r0    = {1'b0, since_ff};
            div_d     = {1'b0, rt};
         end
         rap_pkg::ST_SCALE_GO: begin
            mul_start = 1'b1;
            mul_a     = rap_pkg::MAG_W'(diff_mag);
            mul_b     = BW'(frac_ff);
         end
         rap_pkg::ST_KD_GO: begin
            mul_start = 1'b1;
            mul_a     = rap_pkg::MAG_W'(diffq_mag);
            mul_b     = BW'(rap_pkg::GAIN_D[axis_ff]);
         end
         rap_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            div_steps = rap_pkg::DIV_STEPS;
            div_q0    = rap_pkg::DIVQ_W'(num_mag);
            div_d     = {1'b0, dt_ff} + 1'b1;
         end
         rap_pkg::ST_EDT_GO: begin
            mul_start = 1'b1;
            mul_a     = rap_pkg::MAG_W'(eq_mag);
            mul_b     = BW'(dt_ff);
         end
         rap_pkg::ST_KP_GO: begin
            mul_start = 1'b1;
            mul_a     = rap_pkg::MAG_W'(eq_mag);
            mul_b     = BW'(rap_pkg::GAIN_P[axis_ff]);
         end
         rap_pkg::ST_KI_GO: begin
            mul_start = 1'b1;
            mul_a     = rap_pkg::MAG_W'(int_mag);
            mul_b     = BW'(rap_pkg::GAIN_I[axis_ff]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rap_pkg::ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ramp_ff      <= '0;
         start_ff     <= '0;
         last_ff      <= '0;
         for (int i = 0; i < rap_pkg::AXES; i++) begin
            target_ff[i] <= '0;
            init_ff[i]   <= '0;
            lerr_ff[i]   <= '0;
            fd_ff[i]     <= '0;
            int_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               rap_pkg::REG_TARGET_X:  target_ff[0] <= csr_wdata[AW-1:0];
               rap_pkg::REG_TARGET_Y:  target_ff[1] <= csr_wdata[AW-1:0];
               rap_pkg::REG_TARGET_Z:  target_ff[2] <= csr_wdata[AW-1:0];
               rap_pkg::REG_RAMP_TIME: ramp_ff      <= csr_wdata[31:0];
            endcase
         end

         if (state_ff == rap_pkg::ST_DONE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            rap_pkg::ST_IDLE: begin
               axis_ff <= '0;
               if (req_acc) begin
                  if (req_tuser == rap_pkg::OP_START) begin
                     start_ff <= now_in;
                     last_ff  <= now_in;
                     for (int i = 0; i < rap_pkg::AXES; i++) begin
                        init_ff[i] <= att_in[i];
                        lerr_ff[i] <= '0;
                        fd_ff[i]   <= '0;
                        int_ff[i]  <= '0;
                     end
                  end else begin
                     now_ff <= now_in;
                     for (int i = 0; i < rap_pkg::AXES; i++) begin
                        meas_ff[i] <= att_in[i];
                     end
                  end
               end
            end
            rap_pkg::ST_PREP: begin
               dt_ff        <= now_ff - last_ff;
               since_ff     <= now_ff - start_ff;
               ramp_done_ff <= (now_ff - start_ff) >= rt;
               last_ff      <= now_ff;
            end
            rap_pkg::ST_FRAC_WAIT:
               if (div_stat.done)
                  frac_ff <= ramp_done_ff ? '0 : div_quot[rap_pkg::FRAC_BITS-1:0];
            rap_pkg::ST_SCALE_GO: sgn_ff <= diff_s[AW];
            rap_pkg::ST_SCALE_WAIT:
               if (mul_stat.done)
                  sp_ff <= ramp_done_ff ? (AW+2)'(target_ff[axis_ff]) : sp_calc;
            rap_pkg::ST_ERR: e_ff <= e_sat;
            rap_pkg::ST_KD_GO: begin
               eq_ff  <= eq_cur;
               sgn_ff <= diffq[QW];
            end
            rap_pkg::ST_KD_WAIT:
               if (mul_stat.done)
                  mgd_ff <= rap_pkg::apply_sign(gain_prod, sgn_ff);
            rap_pkg::ST_NUM: num_ff <= mgd_ff + (QW+2)'(fd_ff[axis_ff]);
            rap_pkg::ST_DIV_GO: sgn_ff <= num_ff[QW+1];
            rap_pkg::ST_DIV_WAIT:
               if (div_stat.done)
                  d_ff <= rap_pkg::sat_q(rap_pkg::apply_sign(qv, sgn_ff));
            rap_pkg::ST_EDT_GO: sgn_ff <= eq_ff[QW-1];
            rap_pkg::ST_EDT_WAIT:
               if (mul_stat.done) p_ff <= rap_pkg::apply_sign(pm, sgn_ff);
            rap_pkg::ST_INT: begin
               int_ff[axis_ff]  <= rap_pkg::sat_q((QW+2)'(int_ff[axis_ff]) + p_ff);
               lerr_ff[axis_ff] <= e_ff;
               fd_ff[axis_ff]   <= d_ff;
            end
            rap_pkg::ST_KP_GO: sgn_ff <= eq_ff[QW-1];
            rap_pkg::ST_KP_WAIT:
               if (mul_stat.done)
                  tp_ff <= rap_pkg::apply_sign(gain_prod, sgn_ff);
            rap_pkg::ST_KI_GO: sgn_ff <= int_ff[axis_ff][QW-1];
            rap_pkg::ST_KI_WAIT:
               if (mul_stat.done)
                  ti_ff <= rap_pkg::apply_sign(gain_prod, sgn_ff);
            rap_pkg::ST_SUM: sum_ff <= tp_ff + (QW+2)'(d_ff) + ti_ff;
            rap_pkg::ST_SAT: begin
               tq_ff[axis_ff] <= rap_pkg::sat_q(-sum_ff);
               if (!last_axis) axis_ff <= axis_ff + 1'b1;
            end
            rap_pkg::ST_DONE:
               if (out_free) begin
                  rsp_data_ff <= RSP_W'({tq_ff[2], tq_ff[1], tq_ff[0]});
                  rsp_user_ff <= ramp_done_ff;
               end
            default: begin
            end
         endcase
      end
   end

   rap_mul #(
      .BW    (BW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .stat  (mul_stat)
   );

   rap_div #(
      .TW    (TW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .steps (div_steps),
      .r0    (div_r0),
      .q0    (div_q0),
      .d     (div_d),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   assign req_tready = state_ff == rap_pkg::ST_IDLE;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // the two serial units never run at the same time
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!mul_stat.busy && !div_stat.busy))
      else $error("input ready while a unit is running");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == rap_pkg::ST_SCALE_WAIT ||
                         state_ff == rap_pkg::ST_KD_WAIT ||
                         state_ff == rap_pkg::ST_EDT_WAIT ||
                         state_ff == rap_pkg::ST_KP_WAIT ||
                         state_ff == rap_pkg::ST_KI_WAIT))
      else $error("multiplier result outside a wait state");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == rap_pkg::ST_FRAC_WAIT ||
                         state_ff == rap_pkg::ST_DIV_WAIT))
      else $error("divider result outside a wait state");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rap_pkg::ST_DONE && rsp_tvalid && !rsp_tready)
         |=> state_ff == rap_pkg::ST_DONE)
      else $error("finished step overwrote a stalled beat");

endmodule

`default_nettype wire
